>>> hw/rtl/ptc_pkg.sv
// Package with the request codes, constants and helpers of the pausable tick-to-time clock.
`timescale 1ns / 1ps

package ptc_pkg;

	// Width of tick counts and of times in 100 ns units.
	localparam int unsigned TickW = 63;
	// Width of a tick count times the number of 100 ns units in a second.
	localparam int unsigned ProdW = 87;
	// Width of the tick frequency register and of the divider remainder.
	localparam int unsigned FreqW = 32;
	// Width of the seconds-to-100-ns scale constant.
	localparam int unsigned HnsW = 24;
	// Width of the step counter of the shared unit.
	localparam int unsigned CntW = 7;

	localparam logic [HnsW-1:0]  HNS_PER_SECOND = 24'd10000000;
	localparam logic [TickW-1:0] MAX63          = {TickW{1'b1}};
	localparam logic [FreqW-1:0] FREQ_RESET     = 32'd10000000;

	// Index of the last step, counted down to zero, of the shift-and-add multiply and of the long division.
	localparam logic [CntW-1:0] MUL_LAST_STEP = 7'(HnsW - 1);
	localparam logic [CntW-1:0] DIV_LAST_STEP = 7'(ProdW - 1);

	// Request codes carried by req_type.
	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_PAUSE  = 2'd1,
		REQ_RESUME = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	// What a finished conversion is used for; a query that answers zero skips conversion.
	typedef enum logic [1:0] {
		CONV_RESUME   = 2'd0,
		CONV_QPAUSE   = 2'd1,
		CONV_QELAPSED = 2'd2,
		CONV_QZERO    = 2'd3
	} conv_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Adds two 63-bit values and saturates at the largest 63-bit value.
	function automatic logic [TickW-1:0] sat_add63(input logic [TickW-1:0] a,
			input logic [TickW-1:0] b);
		logic [TickW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TickW] ? MAX63 : s[TickW-1:0];
	endfunction

endpackage

>>> hw/rtl/pausable_tick_to_time_clock.sv
// Pausable stopwatch that turns free-running tick counts into elapsed time in 100 ns units.
// Start, pause and an ignored resume complete in the idle state; a query that answers zero passes through done.
// A converting resume or query runs 24 multiply and 87 divide steps on the shared shift-add/subtract
// unit between accept and finish; a query's beat is loaded into the output register at the finish.
// A query during a pause, with ticks since the pause, converts twice; a held beat stalls the finish.
// Reset (arst_n low) stops the clock, clears the pause state and sets the frequency to 10 MHz.
`timescale 1ns / 1ps

module pausable_tick_to_time_clock import ptc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [TickW-1:0] tick_now,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [TickW-1:0] elapsed_time,
	input  logic             cfg_wr_en,
	input  logic [FreqW-1:0] cfg_wr_data
);

	state_t            state_q;
	conv_t             conv_q;
	logic [FreqW-1:0]  freq_q;
	logic [TickW-1:0]  start_tick_q;
	logic [TickW-1:0]  pause_tick_q;
	logic [TickW-1:0]  paused_total_q;
	logic              is_paused_q;
	logic              is_started_q;
	logic [TickW-1:0]  delta_q;
	logic [TickW-1:0]  elapsed_delta_q;
	logic [TickW-1:0]  hold_q;
	logic [ProdW-1:0]  acc_q;
	logic [FreqW-1:0]  rem_q;
	logic [CntW-1:0]   cnt_q;
	logic              out_valid_q;
	logic [TickW-1:0]  out_data_q;

	logic              accept;
	req_t              req;
	logic [ProdW-1:0]  mul_next;
	logic [FreqW:0]    div_partial;
	logic              div_ge;
	logic [FreqW:0]    div_diff;
	logic [TickW-1:0]  conv_result;
	logic              out_free;
	logic              load_out;
	logic [TickW-1:0]  load_data;

	assign in_ready     = (state_q == ST_IDLE);
	assign accept       = in_valid && in_ready;
	assign req          = req_t'(req_type);
	assign out_valid    = out_valid_q;
	assign elapsed_time = out_data_q;
	assign out_free     = !out_valid_q || out_ready;

	// Multiply step: most significant constant bit first, shift and add the tick delta.
	assign mul_next = {acc_q[ProdW-2:0], 1'b0}
		+ (HNS_PER_SECOND[cnt_q[4:0]] ? {{(ProdW-TickW){1'b0}}, delta_q} : '0);

	// Divide step: restoring division, quotient bits shift into the low end of acc_q.
	assign div_partial = {rem_q, acc_q[ProdW-1]};
	assign div_ge      = (div_partial >= {1'b0, freq_q});
	assign div_diff    = div_partial - {1'b0, freq_q};

	// A quotient beyond 63 bits saturates.
	assign conv_result = (acc_q[ProdW-1:TickW] != '0) ? MAX63 : acc_q[TickW-1:0];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (cfg_wr_en) begin
			freq_q <= cfg_wr_data;
		end
	end

	// Request handling and the conversion sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			conv_q          <= CONV_RESUME;
			start_tick_q    <= '0;
			pause_tick_q    <= '0;
			paused_total_q  <= '0;
			is_paused_q     <= 1'b0;
			is_started_q    <= 1'b0;
			delta_q         <= '0;
			elapsed_delta_q <= '0;
			hold_q          <= '0;
			acc_q           <= '0;
			rem_q           <= '0;
			cnt_q           <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_START: begin
								start_tick_q   <= tick_now;
								pause_tick_q   <= '0;
								paused_total_q <= '0;
								is_paused_q    <= 1'b0;
								is_started_q   <= 1'b1;
							end
							REQ_PAUSE: begin
								if (is_started_q && !is_paused_q) begin
									pause_tick_q <= tick_now;
									is_paused_q  <= 1'b1;
								end
							end
							REQ_RESUME: begin
								if (is_started_q && is_paused_q) begin
									pause_tick_q <= '0;
									is_paused_q  <= 1'b0;
									if (tick_now > pause_tick_q && freq_q != '0) begin
										delta_q <= tick_now - pause_tick_q;
										conv_q  <= CONV_RESUME;
										acc_q   <= '0;
										cnt_q   <= MUL_LAST_STEP;
										state_q <= ST_MUL;
									end
								end
							end
							REQ_QUERY: begin
								if (!is_started_q || freq_q == '0 || tick_now <= start_tick_q) begin
									conv_q  <= CONV_QZERO;
									state_q <= ST_DONE;
								end else begin
									acc_q <= '0;
									cnt_q <= MUL_LAST_STEP;
									state_q <= ST_MUL;
									elapsed_delta_q <= tick_now - start_tick_q;
									hold_q <= paused_total_q;
									if (is_paused_q && tick_now > pause_tick_q) begin
										delta_q <= tick_now - pause_tick_q;
										conv_q  <= CONV_QPAUSE;
									end else begin
										delta_q <= tick_now - start_tick_q;
										conv_q  <= CONV_QELAPSED;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					acc_q <= mul_next;
					if (cnt_q == '0) begin
						rem_q   <= '0;
						cnt_q   <= DIV_LAST_STEP;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? div_diff[FreqW-1:0] : div_partial[FreqW-1:0];
					acc_q <= {acc_q[ProdW-2:0], div_ge};
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					unique case (conv_q)
						CONV_RESUME: begin
							paused_total_q <= sat_add63(paused_total_q, conv_result);
							state_q        <= ST_IDLE;
						end
						CONV_QPAUSE: begin
							// The pause in progress is added, then the elapsed span is converted.
							hold_q  <= sat_add63(hold_q, conv_result);
							delta_q <= elapsed_delta_q;
							conv_q  <= CONV_QELAPSED;
							acc_q   <= '0;
							cnt_q   <= MUL_LAST_STEP;
							state_q <= ST_MUL;
						end
						default: begin
							if (out_free) begin
								state_q <= ST_IDLE;
							end
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A finished query loads its answer once the output register is free.
	always_comb begin
		load_out  = 1'b0;
		load_data = '0;
		if (state_q == ST_DONE && (conv_q == CONV_QELAPSED || conv_q == CONV_QZERO)
				&& out_free) begin
			load_out = 1'b1;
			if (conv_q == CONV_QELAPSED && conv_result > hold_q) begin
				load_data = conv_result - hold_q;
			end
		end
	end

	// Output register; a finished query waits here until the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_data_q  <= load_data;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
